// File: rtl/atq_pkg.sv
`timescale 1ns / 1ps

package atq_pkg;

  // Default geometry of the queue.
  localparam int unsigned QueueDepthDef = 32;
  localparam int unsigned HandleBitsDef = 16;
  localparam int unsigned WorkerBitsDef = 8;

  // Request codes on req_type_i.
  typedef enum logic {
    REQ_ADD   = 1'b0,
    REQ_FETCH = 1'b1
  } atq_req_e;

  // Sequencer states: a fetch removes its entry in a separate remove state.
  typedef enum logic {
    ST_IDLE   = 1'b0,
    ST_REMOVE = 1'b1
  } atq_state_e;

  // Command broadcast from the sequencer to every cell.
  typedef struct packed {
    logic add;      // append the incoming entry at the tail cell
    logic capture;  // register each cell's affinity match
    logic remove;   // drop the first matching entry and close the gap
  } atq_cmd_t;

endpackage

// File: rtl/affinity_task_queue_top.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake             Ports
// request   in         start / busy          req_type_i task_handle_i affinity_any_i
//                                            affinity_worker_i requester_i
// result    out        done_o (one cycle)    granted_o out_handle_o wake_others_o
//                                            add_rejected_o entries_o
//
// An add beat's result appears on the following cycle and a new beat may be
// taken at once.
// A fetch beat first registers every cell's affinity compare, then removes
// the oldest match and shifts the younger cells down by one; busy is high
// during that remove step.
// rst_ni clears the fill count and the sequencer; entry storage is not reset.
// The receiver cannot stall: each result is shown for exactly one cycle.

module affinity_task_queue_top #(
  parameter int unsigned QUEUE_DEPTH = atq_pkg::QueueDepthDef,
  parameter int unsigned HANDLE_BITS = atq_pkg::HandleBitsDef,
  parameter int unsigned WORKER_BITS = atq_pkg::WorkerBitsDef,
  localparam int unsigned CNT_W      = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  input  logic                   req_type_i,
  input  logic [HANDLE_BITS-1:0] task_handle_i,
  input  logic                   affinity_any_i,
  input  logic [WORKER_BITS-1:0] affinity_worker_i,
  input  logic [WORKER_BITS-1:0] requester_i,
  output logic                   done_o,
  output logic                   granted_o,
  output logic [HANDLE_BITS-1:0] out_handle_o,
  output logic                   wake_others_o,
  output logic                   add_rejected_o,
  output logic [CNT_W-1:0]       entries_o
);
  import atq_pkg::*;

  atq_state_e             state_q, state_d;
  atq_cmd_t               cmd;
  logic [CNT_W-1:0]       count_q, count_d;
  logic                   accept;
  logic                   is_fetch;
  logic                   full;

  logic                   done_q, done_d;
  logic                   granted_q, granted_d;
  logic [HANDLE_BITS-1:0] handle_q, handle_d;
  logic                   wake_q, wake_d;
  logic                   rejected_q, rejected_d;

  logic [QUEUE_DEPTH-1:0]                  tail;
  logic [QUEUE_DEPTH-1:0]                  valid;
  logic [QUEUE_DEPTH:0]                    prior;
  logic [QUEUE_DEPTH-1:0][HANDLE_BITS-1:0] cell_handle;
  logic [QUEUE_DEPTH-1:0]                  cell_any;
  logic [QUEUE_DEPTH-1:0][WORKER_BITS-1:0] cell_worker;
  logic [QUEUE_DEPTH-1:0][HANDLE_BITS-1:0] pick_handle;
  logic [HANDLE_BITS-1:0]                  picked;

  assign busy     = (state_q == ST_REMOVE);
  assign accept   = start & ~busy;
  assign is_fetch = (req_type_i == REQ_FETCH);
  assign full     = (count_q == CNT_W'(QUEUE_DEPTH));

  assign prior[0] = 1'b0;

  // Row of cells, oldest entry in cell 0.
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic [HANDLE_BITS-1:0] nxt_handle;
    logic                   nxt_any;
    logic [WORKER_BITS-1:0] nxt_worker;

    assign tail[i]  = (count_q == CNT_W'(i));
    assign valid[i] = (CNT_W'(i) < count_q);

    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign nxt_handle = '0;
      assign nxt_any    = 1'b0;
      assign nxt_worker = '0;
    end else begin : g_mid
      assign nxt_handle = cell_handle[i+1];
      assign nxt_any    = cell_any[i+1];
      assign nxt_worker = cell_worker[i+1];
    end

    atq_cell #(
      .HANDLE_BITS(HANDLE_BITS),
      .WORKER_BITS(WORKER_BITS)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .cmd_i        (cmd),
      .tail_i       (tail[i]),
      .valid_i      (valid[i]),
      .requester_i  (requester_i),
      .add_handle_i (task_handle_i),
      .add_any_i    (affinity_any_i),
      .add_worker_i (affinity_worker_i),
      .next_handle_i(nxt_handle),
      .next_any_i   (nxt_any),
      .next_worker_i(nxt_worker),
      .prior_i      (prior[i]),
      .prior_o      (prior[i+1]),
      .handle_o     (cell_handle[i]),
      .any_o        (cell_any[i]),
      .worker_o     (cell_worker[i]),
      .pick_handle_o(pick_handle[i])
    );
  end

  // At most one cell is hit, so an OR gathers its handle.
  always_comb begin
    picked = '0;
    for (int unsigned k = 0; k < QUEUE_DEPTH; k++) begin
      picked = picked | pick_handle[k];
    end
  end

  // Sequencer: next state, cell commands and result values.
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    cmd         = '0;
    done_d      = 1'b0;
    granted_d   = granted_q;
    handle_d    = handle_q;
    wake_d      = wake_q;
    rejected_d  = rejected_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (is_fetch) begin
            cmd.capture = 1'b1;
            state_d     = ST_REMOVE;
          end else begin
            cmd.add    = ~full;
            done_d     = 1'b1;
            granted_d  = 1'b0;
            handle_d   = '0;
            wake_d     = 1'b0;
            rejected_d = full;
            if (!full) begin
              count_d = count_q + CNT_W'(1);
            end
          end
        end
      end
      ST_REMOVE: begin
        cmd.remove = 1'b1;
        done_d     = 1'b1;
        granted_d  = prior[QUEUE_DEPTH];
        handle_d   = picked;
        rejected_d = 1'b0;
        if (prior[QUEUE_DEPTH]) begin
          count_d = count_q - CNT_W'(1);
        end
        wake_d  = (count_d != '0);
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      done_q  <= done_d;
    end
  end

  // Result registers.
  always_ff @(posedge clk_i) begin
    granted_q  <= granted_d;
    handle_q   <= handle_d;
    wake_q     <= wake_d;
    rejected_q <= rejected_d;
  end

  assign done_o         = done_q;
  assign granted_o      = granted_q;
  assign out_handle_o   = handle_q;
  assign wake_others_o  = wake_q;
  assign add_rejected_o = rejected_q;
  assign entries_o      = count_q;

  // A fetch beat always enters the remove step, which then ends with done_o raised.
  a_fetch_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && is_fetch) |=> (busy && !done_o))
    else $error("fetch beat did not enter the remove step");

  a_busy_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |=> (!busy && done_o))
    else $error("remove step did not finish in one cycle");

  // The fill count never exceeds the number of cells.
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(QUEUE_DEPTH))
    else $error("fill count out of range");

  // A grant lowers the count by one and wake follows what remains.
  a_grant_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |=> (granted_o ? (entries_o == $past(count_q) - CNT_W'(1))
                        : (entries_o == $past(count_q))))
    else $error("fill count does not follow the fetch outcome");

  a_wake: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && granted_o) |-> (wake_others_o == (entries_o != '0)))
    else $error("wake flag disagrees with the remaining entries");

endmodule

// File: rtl/atq_cell.sv
`timescale 1ns / 1ps

module atq_cell #(
  parameter int unsigned HANDLE_BITS = atq_pkg::HandleBitsDef,
  parameter int unsigned WORKER_BITS = atq_pkg::WorkerBitsDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  atq_pkg::atq_cmd_t      cmd_i,
  input  logic                   tail_i,
  input  logic                   valid_i,
  input  logic [WORKER_BITS-1:0] requester_i,
  input  logic [HANDLE_BITS-1:0] add_handle_i,
  input  logic                   add_any_i,
  input  logic [WORKER_BITS-1:0] add_worker_i,
  input  logic [HANDLE_BITS-1:0] next_handle_i,
  input  logic                   next_any_i,
  input  logic [WORKER_BITS-1:0] next_worker_i,
  input  logic                   prior_i,
  output logic                   prior_o,
  output logic [HANDLE_BITS-1:0] handle_o,
  output logic                   any_o,
  output logic [WORKER_BITS-1:0] worker_o,
  output logic [HANDLE_BITS-1:0] pick_handle_o
);
  import atq_pkg::*;

  logic [HANDLE_BITS-1:0] handle_q;
  logic                   any_q;
  logic [WORKER_BITS-1:0] worker_q;
  logic                   match_q;
  logic                   hit;

  // A cell is hit when it matches and no older cell matched.
  assign hit     = match_q & ~prior_i;
  assign prior_o = prior_i | match_q;

  assign handle_o      = handle_q;
  assign any_o         = any_q;
  assign worker_o      = worker_q;
  assign pick_handle_o = hit ? handle_q : '0;

  // Entry storage: load at the tail on add, take the younger neighbor on remove.
  always_ff @(posedge clk_i) begin
    if (cmd_i.add && tail_i) begin
      handle_q <= add_handle_i;
      any_q    <= add_any_i;
      worker_q <= add_worker_i;
    end else if (cmd_i.remove && prior_o) begin
      handle_q <= next_handle_i;
      any_q    <= next_any_i;
      worker_q <= next_worker_i;
    end
  end

  // Affinity compare, taken for every cell at once when a fetch beat arrives.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
    end else if (cmd_i.capture) begin
      match_q <= valid_i & (any_q | (worker_q == requester_i));
    end
  end

endmodule

// File: verif/tb_affinity_task_queue_top.sv
`timescale 1ns / 1ps

module tb_affinity_task_queue_top;
  import atq_pkg::*;

  localparam int unsigned Depth      = QueueDepthDef;
  localparam int unsigned HandleBits = HandleBitsDef;
  localparam int unsigned WorkerBits = WorkerBitsDef;
  localparam int unsigned CountBits  = $clog2(Depth + 1);
  localparam int unsigned HalfPeriod = 6;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned RandomBeats = 550;
  localparam int unsigned DrainCycles = 8;

  // One request beat as the sender presents it.
  typedef struct {
    atq_req_e              kind;
    logic [HandleBits-1:0] handle;
    logic                  any;
    logic [WorkerBits-1:0] worker;
    logic [WorkerBits-1:0] requester;
  } request_t;

  // One response beat as the block shows it.
  typedef struct {
    logic                  granted;
    logic [HandleBits-1:0] handle;
    logic                  wake_others;
    logic                  add_rejected;
    logic [CountBits-1:0]  entries;
  } response_t;

  // Keeps its own copy of the task queue and the responses still owed.
  class TaskQueueScoreboard;
    int unsigned           errors;
    response_t             due_responses[$];
    logic [HandleBits-1:0] queued_handle[$];
    logic                  queued_any[$];
    logic [WorkerBits-1:0] queued_worker[$];

    function new();
      errors = 0;
    endfunction

    task report(string msg);
      errors++;
      $display("[%0t] mismatch: %s", $time, msg);
    endtask

    // Apply an accepted request to the queue copy and note its response.
    function void note_request(request_t r);
      response_t rsp;
      int        hit;
      rsp.granted      = 1'b0;
      rsp.handle       = '0;
      rsp.wake_others  = 1'b0;
      rsp.add_rejected = 1'b0;
      if (r.kind == REQ_ADD) begin
        if (queued_handle.size() >= Depth) begin
          rsp.add_rejected = 1'b1;
        end else begin
          queued_handle.insert(queued_handle.size(), r.handle);
          queued_any.insert(queued_any.size(), r.any);
          queued_worker.insert(queued_worker.size(), r.worker);
        end
      end else begin
        // Oldest entry that is free for any worker or pinned to the requester.
        hit = -1;
        for (int i = 0; i < queued_handle.size(); i++) begin
          if (hit < 0 && (queued_any[i] || queued_worker[i] == r.requester)) begin
            hit = i;
          end
        end
        if (hit >= 0) begin
          rsp.granted = 1'b1;
          rsp.handle  = queued_handle[hit];
          queued_handle.delete(hit);
          queued_any.delete(hit);
          queued_worker.delete(hit);
        end
        rsp.wake_others = (queued_handle.size() > 0);
      end
      rsp.entries = CountBits'(queued_handle.size());
      due_responses.insert(due_responses.size(), rsp);
    endfunction

    // Compare a shown response with the oldest one owed.
    task check_response(response_t got);
      response_t want;
      if (due_responses.size() == 0) begin
        report($sformatf("response with none owed (handle 0x%0h)", got.handle));
      end else begin
        want = due_responses.pop_front();
        if (got.granted !== want.granted)
          report($sformatf("granted got %0b want %0b", got.granted, want.granted));
        if (got.handle !== want.handle)
          report($sformatf("out_handle got 0x%0h want 0x%0h", got.handle, want.handle));
        if (got.wake_others !== want.wake_others)
          report($sformatf("wake_others got %0b want %0b", got.wake_others,
                           want.wake_others));
        if (got.add_rejected !== want.add_rejected)
          report($sformatf("add_rejected got %0b want %0b", got.add_rejected,
                           want.add_rejected));
        if (got.entries !== want.entries)
          report($sformatf("entries got %0d want %0d", got.entries, want.entries));
      end
    endtask
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  start;
  logic                  busy;
  logic                  req_type_i;
  logic [HandleBits-1:0] task_handle_i;
  logic                  affinity_any_i;
  logic [WorkerBits-1:0] affinity_worker_i;
  logic [WorkerBits-1:0] requester_i;
  logic                  done_o;
  logic                  granted_o;
  logic [HandleBits-1:0] out_handle_o;
  logic                  wake_others_o;
  logic                  add_rejected_o;
  logic [CountBits-1:0]  entries_o;

  TaskQueueScoreboard sb = new();
  int unsigned cycle_count = 0;

  affinity_task_queue_top DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .req_type_i       (req_type_i),
    .task_handle_i    (task_handle_i),
    .affinity_any_i   (affinity_any_i),
    .affinity_worker_i(affinity_worker_i),
    .requester_i      (requester_i),
    .done_o           (done_o),
    .granted_o        (granted_o),
    .out_handle_o     (out_handle_o),
    .wake_others_o    (wake_others_o),
    .add_rejected_o   (add_rejected_o),
    .entries_o        (entries_o)
  );

  always begin
    #(HalfPeriod) clk_i = 1'b1;
    #(HalfPeriod) clk_i = 1'b0;
  end

  // Run guard: a hung block ends the run as a failure.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Every response beat is shown for one cycle and taken at the closing edge.
  always @(posedge clk_i) begin
    response_t got;
    if (rst_ni && done_o) begin
      got.granted      = granted_o;
      got.handle       = out_handle_o;
      got.wake_others  = wake_others_o;
      got.add_rejected = add_rejected_o;
      got.entries      = entries_o;
      sb.check_response(got);
    end
  end

  // Present one request beat and hold it until the block takes it.
  task automatic present(request_t r);
    @(negedge clk_i);
    start             <= 1'b1;
    req_type_i        <= r.kind;
    task_handle_i     <= r.handle;
    affinity_any_i    <= r.any;
    affinity_worker_i <= r.worker;
    requester_i       <= r.requester;
    do @(posedge clk_i); while (busy);
    sb.note_request(r);
  endtask

  // Idle cycles carry junk on the data lines with start low.
  task automatic idle(int unsigned n);
    repeat (n) begin
      @(negedge clk_i);
      start             <= 1'b0;
      req_type_i        <= 1'($urandom);
      task_handle_i     <= HandleBits'($urandom);
      affinity_any_i    <= 1'($urandom);
      affinity_worker_i <= WorkerBits'($urandom);
      requester_i       <= WorkerBits'($urandom);
    end
  endtask

  task automatic send(atq_req_e kind, int unsigned handle, bit any, int unsigned worker,
                      int unsigned requester);
    request_t r;
    r.kind      = kind;
    r.handle    = HandleBits'(handle);
    r.any       = any;
    r.worker    = WorkerBits'(worker);
    r.requester = WorkerBits'(requester);
    present(r);
  endtask

  // Workers mostly come from a small pool so that pinned entries find takers.
  function automatic logic [WorkerBits-1:0] pick_worker();
    if ($urandom_range(99) < 75) return WorkerBits'($urandom_range(3));
    return WorkerBits'($urandom);
  endfunction

  function automatic request_t random_request(int unsigned add_pct);
    request_t r;
    r.kind      = ($urandom_range(99) < add_pct) ? REQ_ADD : REQ_FETCH;
    r.handle    = HandleBits'($urandom);
    r.any       = ($urandom_range(99) < 35);
    r.worker    = pick_worker();
    r.requester = pick_worker();
    return r;
  endfunction

  initial begin
    int unsigned add_pct;
    rst_ni            = 1'b0;
    start             = 1'b0;
    req_type_i        = REQ_ADD;
    task_handle_i     = '0;
    affinity_any_i    = 1'b0;
    affinity_worker_i = '0;
    requester_i       = '0;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty fetches, field extremes, any versus pinned, order kept.
    send(REQ_FETCH, 16'hFFFF, 1'b1, 8'hFF, 8'h00);
    send(REQ_FETCH, 16'h0000, 1'b0, 8'h00, 8'hFF);
    send(REQ_ADD,   16'hFFFF, 1'b0, 8'hFF, 8'h00);
    send(REQ_ADD,   16'h0000, 1'b0, 8'h00, 8'hFF);
    send(REQ_ADD,   16'h1234, 1'b1, 8'h07, 8'h00);
    send(REQ_ADD,   16'hA5A5, 1'b0, 8'h80, 8'h7F);
    send(REQ_FETCH, 16'h0000, 1'b0, 8'h00, 8'h05);
    send(REQ_FETCH, 16'h0000, 1'b0, 8'h00, 8'h03);
    send(REQ_FETCH, 16'hFFFF, 1'b1, 8'hFF, 8'h80);
    send(REQ_FETCH, 16'h0000, 1'b0, 8'h00, 8'h00);
    send(REQ_FETCH, 16'h0000, 1'b0, 8'h00, 8'h00);
    send(REQ_FETCH, 16'h0000, 1'b0, 8'h00, 8'hFF);
    send(REQ_FETCH, 16'h0000, 1'b0, 8'h00, 8'hFF);
    send(REQ_ADD,   16'h8001, 1'b1, 8'hFF, 8'hFF);
    send(REQ_FETCH, 16'hFFFF, 1'b0, 8'hFF, 8'hFF);
    idle(3);

    // Random: fill, drain and mixed phases so the queue often runs full.
    for (int unsigned k = 0; k < RandomBeats; k++) begin
      case ((k / 60) % 3)
        0: begin
          add_pct = 85;
        end
        1: begin
          add_pct = 20;
        end
        default: begin
          add_pct = 55;
        end
      endcase
      if ((k < 250 || k >= 380) && $urandom_range(99) < 16) idle($urandom_range(1, 4));
      present(random_request(add_pct));
    end
    idle(1);

    // Wait out every owed response, then let the block drain before the verdict.
    while (sb.due_responses.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/atq_pkg.sv
rtl/atq_cell.sv
rtl/affinity_task_queue_top.sv
verif/tb_affinity_task_queue_top.sv
